@@ hdl/vpac_pkg.sv @@
package vpac_pkg;

    // Port access modes
    localparam logic [1:0] MODE_DATA_WR = 2'd0;
    localparam logic [1:0] MODE_DATA_RD = 2'd1;
    localparam logic [1:0] MODE_CTRL_WR = 2'd2;
    localparam logic [1:0] MODE_CTRL_RD = 2'd3;

    // Full span of the 16-bit port address
    localparam int ADDR_SPAN = 65536;

    // Color and scroll RAM geometry
    localparam int SMALL_WORDS = 64;
    localparam int SMALL_AW    = $clog2(SMALL_WORDS);

    // Status word with both blank bits clear
    localparam logic [15:0] STATUS_WORD = 16'h3401;

    // Operations passed from the front end to the memory engine
    typedef logic [3:0] op_kind_t;
    localparam op_kind_t OP_VRAM_WR     = 4'd0;
    localparam op_kind_t OP_COLOR_WR    = 4'd1;
    localparam op_kind_t OP_SCROLL_WR   = 4'd2;
    localparam op_kind_t OP_VRAM_FILL   = 4'd3;
    localparam op_kind_t OP_COLOR_FILL  = 4'd4;
    localparam op_kind_t OP_SCROLL_FILL = 4'd5;
    localparam op_kind_t OP_VRAM_RD     = 4'd6;
    localparam op_kind_t OP_COLOR_RD    = 4'd7;
    localparam op_kind_t OP_SCROLL_RD   = 4'd8;
    localparam op_kind_t OP_REPLY       = 4'd9;

    typedef struct packed {
        op_kind_t    kind;
        logic [15:0] addr;
        logic [15:0] data;
        logic [15:0] count;
        logic [7:0]  step;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam int QUEUE_DEPTH = 4;

endpackage

@@ hdl/video_port_access_controller.sv @@
// Port item: captured, then classified; the next item is accepted only once the port is idle
// again, and queue work waits while the queue is full. Memory engine: VRAM write in B_WR_HI then
// B_WR_LO, color/scroll write in B_SWR, fill one write per pass (up to 65536 passes) in B_FILL,
// VRAM read in B_RD_A, B_RD_B, B_RD_C, color/scroll read in B_SRD, B_SRD2, reads and status
// through B_RESP, each after a dequeue in B_IDLE. Reset is synchronous, active low; after it a
// clearing sweep over every VRAM address zeroes all memories, and no item is accepted until it ends.
module video_port_access_controller #(
    parameter int VRAM_BYTES = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [15:0] s_data_word,
    input  logic        s_vblank_flag,
    input  logic        s_hblank_flag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_read_word
);
    import vpac_pkg::*;

    cmd_t    push_cmd, pop_cmd;
    q_stat_t q_stat;
    logic    q_push, q_pop, clear_busy;

    vpac_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_data_word   (s_data_word),
        .s_vblank_flag (s_vblank_flag),
        .s_hblank_flag (s_hblank_flag),
        .clear_busy    (clear_busy),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    vpac_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .stat     (q_stat)
    );

    vpac_back #(
        .VRAM_BYTES (VRAM_BYTES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_stat      (q_stat),
        .q_cmd       (pop_cmd),
        .q_pop       (q_pop),
        .clear_busy  (clear_busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_word (m_read_word)
    );

endmodule

@@ hdl/vpac_front.sv @@
module vpac_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_mode,
    input  logic [15:0]      s_data_word,
    input  logic             s_vblank_flag,
    input  logic             s_hblank_flag,
    input  logic             clear_busy,
    input  vpac_pkg::q_stat_t q_stat,
    output logic             q_push,
    output vpac_pkg::cmd_t   q_cmd
);
    import vpac_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_EXEC = 2'd1;
    localparam logic [1:0] F_FILL = 2'd2;

    // Register numbers and memory codes
    localparam logic [4:0] REG_MODE2   = 5'h01;
    localparam logic [4:0] REG_STEP    = 5'h0F;
    localparam logic [4:0] REG_LEN_LO  = 5'h13;
    localparam logic [4:0] REG_LEN_HI  = 5'h14;
    localparam logic [4:0] REG_DMA_SRC = 5'h17;
    localparam logic [3:0] TGT_VRAM    = 4'd1;
    localparam logic [3:0] TGT_COLOR   = 4'd3;
    localparam logic [3:0] TGT_SCROLL  = 4'd5;
    localparam logic [3:0] SRC_VRAM    = 4'd0;
    localparam logic [3:0] SRC_SCROLL  = 4'd4;
    localparam logic [3:0] SRC_COLOR   = 4'd8;
    localparam logic [1:0] KIND_FILL   = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  mode_reg;
    logic [15:0] word_reg;
    logic        vb_reg, hb_reg;
    logic [5:0]  code_reg, code_next;
    logic [15:0] addr_reg, addr_next;
    logic        second_reg, second_next;
    logic [7:0]  step_reg, step_next;
    logic        dma_on_reg, dma_on_next;
    logic [15:0] count_reg, count_next;
    logic [1:0]  kind_reg, kind_next;
    logic        armed_reg, armed_next;
    logic [15:0] prod_reg;
    logic [23:0] prod_full;

    logic        tgt_ok;
    op_kind_t    wr_kind, fill_kind, rd_kind;
    logic [15:0] wr_data;
    logic [15:0] addr_step16;

    function automatic logic [15:0] pack_color(input logic [15:0] w);
        return {7'b0, w[11:9], w[7:5], w[3:1]};
    endfunction

    assign s_ready     = (state_reg == F_IDLE) && !clear_busy;
    assign addr_step16 = {8'b0, step_reg};
    assign prod_full   = {8'b0, count_reg} * {16'b0, step_reg};

    // Decode write target and read source from the access code
    always_comb begin
        tgt_ok    = 1'b1;
        wr_kind   = OP_VRAM_WR;
        fill_kind = OP_VRAM_FILL;
        wr_data   = word_reg;
        unique case (code_reg[3:0])
            TGT_VRAM: begin
                wr_kind   = OP_VRAM_WR;
                fill_kind = OP_VRAM_FILL;
            end
            TGT_COLOR: begin
                wr_kind   = OP_COLOR_WR;
                fill_kind = OP_COLOR_FILL;
                wr_data   = pack_color(word_reg);
            end
            TGT_SCROLL: begin
                wr_kind   = OP_SCROLL_WR;
                fill_kind = OP_SCROLL_FILL;
            end
            default: tgt_ok = 1'b0;
        endcase
        unique case (code_reg[3:0])
            SRC_VRAM:   rd_kind = OP_VRAM_RD;
            SRC_COLOR:  rd_kind = OP_COLOR_RD;
            SRC_SCROLL: rd_kind = OP_SCROLL_RD;
            default:    rd_kind = OP_REPLY;
        endcase
    end

    // Classify the held item, update port state and issue memory work
    always_comb begin
        state_next  = state_reg;
        code_next   = code_reg;
        addr_next   = addr_reg;
        second_next = second_reg;
        step_next   = step_reg;
        dma_on_next = dma_on_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        armed_next  = armed_reg;
        q_push      = 1'b0;
        q_cmd.kind  = OP_REPLY;
        q_cmd.addr  = addr_reg;
        q_cmd.data  = 16'h0000;
        q_cmd.count = count_reg;
        q_cmd.step  = step_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = F_EXEC;
                end
            end
            F_EXEC: begin
                unique case (mode_reg)
                    MODE_CTRL_WR: begin
                        state_next = F_IDLE;
                        if (word_reg[15:14] == 2'b10) begin
                            unique case (word_reg[12:8])
                                REG_MODE2:   dma_on_next = word_reg[4];
                                REG_STEP:    step_next   = word_reg[7:0];
                                REG_LEN_LO:  count_next  = {count_reg[15:8], word_reg[7:0]};
                                REG_LEN_HI:  count_next  = {word_reg[7:0], count_reg[7:0]};
                                REG_DMA_SRC: kind_next   = word_reg[7:6];
                                default: ;
                            endcase
                        end else if (!second_reg) begin
                            code_next   = {code_reg[5:2], word_reg[15:14]};
                            addr_next   = {addr_reg[15:14], word_reg[13:0]};
                            second_next = 1'b1;
                        end else begin
                            code_next   = {word_reg[7:4], code_reg[1:0]};
                            addr_next   = {word_reg[1:0], addr_reg[13:0]};
                            second_next = 1'b0;
                            if (dma_on_reg && word_reg[7] && (kind_reg == KIND_FILL)) begin
                                armed_next = 1'b1;
                            end
                        end
                    end
                    MODE_DATA_WR: begin
                        if (!(tgt_ok && q_stat.full)) begin
                            second_next = 1'b0;
                            state_next  = F_IDLE;
                            if (tgt_ok) begin
                                q_push     = 1'b1;
                                q_cmd.kind = wr_kind;
                                q_cmd.data = wr_data;
                                addr_next  = addr_reg + addr_step16;
                            end
                            if (dma_on_reg && armed_reg) begin
                                armed_next = 1'b0;
                                if (tgt_ok) begin
                                    state_next = F_FILL;
                                end
                            end
                        end
                    end
                    MODE_DATA_RD: begin
                        if (!q_stat.full) begin
                            q_push      = 1'b1;
                            q_cmd.kind  = rd_kind;
                            second_next = 1'b0;
                            addr_next   = addr_reg + addr_step16;
                            state_next  = F_IDLE;
                        end
                    end
                    MODE_CTRL_RD: begin
                        if (!q_stat.full) begin
                            q_push      = 1'b1;
                            q_cmd.kind  = OP_REPLY;
                            q_cmd.data  = STATUS_WORD | {12'b0, vb_reg, hb_reg, 2'b00};
                            second_next = 1'b0;
                            state_next  = F_IDLE;
                        end
                    end
                    default: state_next = F_IDLE;
                endcase
            end
            F_FILL: begin
                if (!q_stat.full) begin
                    q_push     = 1'b1;
                    q_cmd.kind = fill_kind;
                    q_cmd.data = wr_data;
                    addr_next  = addr_reg + prod_reg;
                    count_next = 16'h0000;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Hold the accepted item
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            word_reg <= s_data_word;
            vb_reg   <= s_vblank_flag;
            hb_reg   <= s_hblank_flag;
        end
        prod_reg <= prod_full[15:0];
    end

    // Advance port state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_IDLE;
            code_reg   <= '0;
            addr_reg   <= '0;
            second_reg <= 1'b0;
            step_reg   <= '0;
            dma_on_reg <= 1'b0;
            count_reg  <= '0;
            kind_reg   <= '0;
            armed_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            code_reg   <= code_next;
            addr_reg   <= addr_next;
            second_reg <= second_next;
            step_reg   <= step_next;
            dma_on_reg <= dma_on_next;
            count_reg  <= count_next;
            kind_reg   <= kind_next;
            armed_reg  <= armed_next;
        end
    end

endmodule

@@ hdl/vpac_queue.sv @@
module vpac_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  vpac_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output vpac_pkg::cmd_t    pop_cmd,
    output vpac_pkg::q_stat_t stat
);
    import vpac_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   fill_reg;

    assign stat.full  = (fill_reg == (PW+1)'(QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    // Store pushed work
    always_ff @(posedge aclk) begin
        if (push && !stat.full) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Track pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push && !stat.full) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !stat.empty) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + (PW+1)'(push && !stat.full) - (PW+1)'(pop && !stat.empty);
        end
    end

endmodule

@@ hdl/vpac_back.sv @@
module vpac_back #(
    parameter int VRAM_BYTES = 65536
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  vpac_pkg::q_stat_t q_stat,
    input  vpac_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    output logic              clear_busy,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_read_word
);
    import vpac_pkg::*;

    localparam int VA_W  = $clog2(VRAM_BYTES);
    localparam int QBITS = $clog2(ADDR_SPAN / VRAM_BYTES + 1);

    localparam logic [3:0] B_CLEAR = 4'd0;
    localparam logic [3:0] B_IDLE  = 4'd1;
    localparam logic [3:0] B_WR_HI = 4'd2;
    localparam logic [3:0] B_WR_LO = 4'd3;
    localparam logic [3:0] B_SWR   = 4'd4;
    localparam logic [3:0] B_FILL  = 4'd5;
    localparam logic [3:0] B_RD_A  = 4'd6;
    localparam logic [3:0] B_RD_B  = 4'd7;
    localparam logic [3:0] B_RD_C  = 4'd8;
    localparam logic [3:0] B_SRD   = 4'd9;
    localparam logic [3:0] B_SRD2  = 4'd10;
    localparam logic [3:0] B_RESP  = 4'd11;

    localparam logic [16:0] FILL_FULL = 17'h10000;

    logic [3:0]      state_reg, state_next;
    cmd_t            cur_reg, cur_next;
    logic [16:0]     cnt_reg, cnt_next;
    logic [15:0]     res_reg, res_next;
    logic            m_valid_reg, m_valid_next;
    logic [15:0]     m_word_reg, m_word_next;
    logic [VA_W-1:0] clr_reg;

    logic [7:0]      vram_mem [VRAM_BYTES];
    logic [8:0]      cram_mem [SMALL_WORDS];
    logic [15:0]     sram_mem [SMALL_WORDS];
    logic [7:0]      vram_q_reg;
    logic [8:0]      cram_q_reg;
    logic [15:0]     sram_q_reg;

    logic                vram_we, cram_we, sram_we;
    logic [VA_W-1:0]     vram_wa, vram_ra;
    logic [7:0]          vram_wd;
    logic [SMALL_AW-1:0] small_wa, small_ra;
    logic [8:0]          cram_wd;
    logic [15:0]         sram_wd;
    logic                clr_last;

    // Reduce a port address to a VRAM index by shifted compare and subtract
    function automatic logic [VA_W-1:0] vram_index(input logic [15:0] a);
        logic [23:0] r;
        r = {8'b0, a};
        for (int k = QBITS - 1; k >= 0; k--) begin
            if (r >= (24'(VRAM_BYTES) << k)) begin
                r = r - (24'(VRAM_BYTES) << k);
            end
        end
        return r[VA_W-1:0];
    endfunction

    function automatic logic [15:0] unpack_color(input logic [8:0] c);
        return {4'b0, c[8:6], 1'b0, c[5:3], 1'b0, c[2:0], 1'b0};
    endfunction

    assign clear_busy  = (state_reg == B_CLEAR);
    assign q_pop       = (state_reg == B_IDLE) && !q_stat.empty;
    assign m_valid     = m_valid_reg;
    assign m_read_word = m_word_reg;
    assign clr_last    = (clr_reg == VA_W'(VRAM_BYTES - 1));

    // Drive memory ports from the current step
    always_comb begin
        vram_we  = 1'b0;
        cram_we  = 1'b0;
        sram_we  = 1'b0;
        vram_wa  = vram_index(cur_reg.addr);
        vram_wd  = cur_reg.data[15:8];
        small_wa = cur_reg.addr[SMALL_AW:1];
        small_ra = cur_reg.addr[SMALL_AW:1];
        cram_wd  = cur_reg.data[8:0];
        sram_wd  = cur_reg.data;
        vram_ra  = vram_index((state_reg == B_RD_B) ? cur_reg.addr + 16'd1 : cur_reg.addr);
        unique case (state_reg)
            B_CLEAR: begin
                vram_we  = 1'b1;
                cram_we  = 1'b1;
                sram_we  = 1'b1;
                vram_wa  = clr_reg;
                vram_wd  = 8'h00;
                small_wa = clr_reg[SMALL_AW-1:0];
                cram_wd  = 9'h000;
                sram_wd  = 16'h0000;
            end
            B_WR_HI: vram_we = 1'b1;
            B_WR_LO: begin
                vram_we = 1'b1;
                vram_wa = vram_index(cur_reg.addr ^ 16'd1);
                vram_wd = cur_reg.data[7:0];
            end
            B_SWR, B_FILL: begin
                case (cur_reg.kind)
                    OP_COLOR_WR, OP_COLOR_FILL:   cram_we = 1'b1;
                    OP_SCROLL_WR, OP_SCROLL_FILL: sram_we = 1'b1;
                    default: begin
                        vram_we = 1'b1;
                        vram_wa = vram_index(cur_reg.addr ^ 16'd1);
                    end
                endcase
            end
            default: ;
        endcase
    end

    // Memory arrays with registered read data
    always_ff @(posedge aclk) begin
        if (vram_we) begin
            vram_mem[vram_wa] <= vram_wd;
        end
        vram_q_reg <= vram_mem[vram_ra];
    end

    always_ff @(posedge aclk) begin
        if (cram_we) begin
            cram_mem[small_wa] <= cram_wd;
        end
        cram_q_reg <= cram_mem[small_ra];
    end

    always_ff @(posedge aclk) begin
        if (sram_we) begin
            sram_mem[small_wa] <= sram_wd;
        end
        sram_q_reg <= sram_mem[small_ra];
    end

    // Sequence each operation taken from the queue
    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next  = m_word_reg;
        unique case (state_reg)
            B_CLEAR: begin
                if (clr_last) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!q_stat.empty) begin
                    cur_next = q_cmd;
                    cnt_next = (q_cmd.count == 16'h0000) ? FILL_FULL : {1'b0, q_cmd.count};
                    res_next = q_cmd.data;
                    case (q_cmd.kind)
                        OP_VRAM_WR:                                state_next = B_WR_HI;
                        OP_COLOR_WR, OP_SCROLL_WR:                 state_next = B_SWR;
                        OP_VRAM_FILL, OP_COLOR_FILL, OP_SCROLL_FILL: state_next = B_FILL;
                        OP_VRAM_RD:                                state_next = B_RD_A;
                        OP_COLOR_RD, OP_SCROLL_RD:                 state_next = B_SRD;
                        default:                                   state_next = B_RESP;
                    endcase
                end
            end
            B_WR_HI: state_next = B_WR_LO;
            B_WR_LO: state_next = B_IDLE;
            B_SWR:   state_next = B_IDLE;
            B_FILL: begin
                cur_next.addr = cur_reg.addr + {8'b0, cur_reg.step};
                cnt_next      = cnt_reg - 17'd1;
                if (cnt_reg == 17'd1) begin
                    state_next = B_IDLE;
                end
            end
            B_RD_A: state_next = B_RD_B;
            B_RD_B: begin
                res_next[15:8] = vram_q_reg;
                state_next     = B_RD_C;
            end
            B_RD_C: begin
                res_next[7:0] = vram_q_reg;
                state_next    = B_RESP;
            end
            B_SRD: state_next = B_SRD2;
            B_SRD2: begin
                res_next   = (cur_reg.kind == OP_COLOR_RD) ? unpack_color(cram_q_reg)
                                                           : sram_q_reg;
                state_next = B_RESP;
            end
            B_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_word_next  = res_reg;
                    state_next   = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Hold operation payload
    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
        m_word_reg <= m_word_next;
    end

    // Advance control state and the clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            m_valid_reg <= 1'b0;
            clr_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == B_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

endmodule
